FILE: design/cleib_pkg.sv
package cleib_pkg;

	localparam int unsigned DEPTH_DEF = 128;

	localparam logic [7:0] KEY_DEL = 8'h7f;
	localparam logic [7:0] KEY_CR  = 8'h0d;
	localparam logic [7:0] KEY_LF  = 8'h0a;
	localparam logic [7:0] KEY_EOT = 8'h04;   // Ctrl-D
	localparam logic [7:0] KEY_BS  = 8'h08;
	localparam logic [7:0] KEY_SP  = 8'h20;
	localparam logic [7:0] KEY_NUL = 8'h00;

	typedef enum logic {
		ACT_KEY  = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_ECHO  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_EOF   = 2'd3
	} kind_t;

endpackage

FILE: design/cleib_req_if.sv
interface cleib_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] key;
	logic       continuing;

	modport source (output valid, output action, output key, output continuing, input ready);
	modport sink   (input valid, input action, input key, input continuing, output ready);
endinterface

FILE: design/cleib_rsp_if.sv
interface cleib_rsp_if;
	logic                valid;
	logic                ready;
	cleib_pkg::kind_t    kind;
	logic [7:0]          byte_out;
	logic                line_end;
	logic                committed;
	logic                last;

	modport source (output valid, output kind, output byte_out, output line_end,
		output committed, output last, input ready);
	modport sink   (input valid, input kind, input byte_out, input line_end,
		input committed, input last, output ready);
endinterface

FILE: design/console_line_edit_input_buffer.sv
// Line-edited keyboard input buffer.
// req carries one item per beat: action 0 delivers a keyboard byte (key), action 1
// asks for one committed byte (continuing set when the same read call already
// took bytes). rsp returns the results of each item; last marks the final one.
// A key gives one echo, none when dropped (null key, full ring, backspace with
// nothing to erase), or three echoes (BS, SP, BS) for a backspace. A read gives
// one result: a byte, "nothing committed" or end of file.
// The block works on one item at a time; req.ready is high only while idle.
// A key or an empty read goes from acceptance through ST_EXEC to its first result
// in ST_SEND; a read that pops the ring also passes through ST_RDATA for the
// registered ring read. A dropped key returns from ST_EXEC to idle with no
// result, and a backspace sends its two extra beats from ST_SEND; the sequencer
// takes no new item until the last result of the current one is taken.
// A stall on rsp holds the result register and keeps req.ready low.
// Reset clears the three pointers (empty ring) and the sequencer; the ring
// contents stay undefined and are only read after being written.
module console_line_edit_input_buffer #(
	parameter int unsigned DEPTH = cleib_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cleib_req_if.sink   req,
	cleib_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = $clog2(2 * DEPTH);
	localparam logic [PW-1:0] P_DEPTH = PW'(DEPTH);
	localparam logic [PW-1:0] P_MAX   = PW'(2 * DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_SEND
	} state_t;

	state_t state_q;

	logic       action_q;
	logic [7:0] key_q;
	logic       cont_q;
	logic [PW-1:0] rd_ptr_q, cm_ptr_q, ed_ptr_q;
	logic       bs_q;
	logic [1:0] beat_q;

	cleib_pkg::kind_t kind_q;
	logic [7:0] byte_q;
	logic       line_end_q, committed_q, last_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == P_MAX) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? P_MAX : p - PW'(1);
	endfunction

	function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= P_DEPTH) ? p - P_DEPTH : p;
		return s[AW-1:0];
	endfunction

	logic [PW-1:0] held;
	logic [PW-1:0] ed_next;
	logic [7:0]    key_char;
	logic          key_store;
	logic          key_commit;
	logic [7:0]    ram_rdata;

	always_comb begin
		if (ed_ptr_q >= rd_ptr_q) begin
			held = ed_ptr_q - rd_ptr_q;
		end else begin
			held = PW'((PW+1)'(ed_ptr_q) + (PW+1)'(2 * DEPTH) - (PW+1)'(rd_ptr_q));
		end
		ed_next    = ptr_inc(ed_ptr_q);
		key_char   = (key_q == cleib_pkg::KEY_CR) ? cleib_pkg::KEY_LF : key_q;
		key_store  = (action_q == cleib_pkg::ACT_KEY) && (key_q != cleib_pkg::KEY_DEL)
			&& (key_q != cleib_pkg::KEY_NUL) && (held < P_DEPTH);
		// ring becomes full with this byte: commit too
		key_commit = (key_char == cleib_pkg::KEY_LF) || (key_char == cleib_pkg::KEY_EOT)
			|| (held == PW'(DEPTH - 1));
	end

	cleib_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    ((state_q == ST_EXEC) && key_store),
		.waddr (slot(ed_ptr_q)),
		.wdata (key_char),
		.raddr (slot(rd_ptr_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ptr_q <= '0;
			cm_ptr_q <= '0;
			ed_ptr_q <= '0;
			bs_q     <= 1'b0;
			beat_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						action_q <= req.action;
						key_q    <= req.key;
						cont_q   <= req.continuing;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					line_end_q  <= 1'b0;
					committed_q <= 1'b0;
					last_q      <= 1'b1;
					bs_q        <= 1'b0;
					beat_q      <= '0;
					kind_q      <= cleib_pkg::KIND_ECHO;
					byte_q      <= key_char;
					if (action_q == cleib_pkg::ACT_KEY) begin
						if (key_q == cleib_pkg::KEY_DEL) begin
							if (ed_ptr_q == cm_ptr_q) begin
								state_q <= ST_IDLE;
							end else begin
								ed_ptr_q <= ptr_dec(ed_ptr_q);
								byte_q   <= cleib_pkg::KEY_BS;
								last_q   <= 1'b0;
								bs_q     <= 1'b1;
								state_q  <= ST_SEND;
							end
						end else if (key_store) begin
							ed_ptr_q    <= ed_next;
							committed_q <= key_commit;
							if (key_commit) begin
								cm_ptr_q <= ed_next;
							end
							state_q <= ST_SEND;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (rd_ptr_q == cm_ptr_q) begin
						kind_q  <= cleib_pkg::KIND_EMPTY;
						byte_q  <= '0;
						state_q <= ST_SEND;
					end else begin
						state_q <= ST_RDATA;
					end
				end
				ST_RDATA: begin
					if (ram_rdata == cleib_pkg::KEY_EOT) begin
						// end of file stays put for the next call when bytes were taken
						if (!cont_q) begin
							rd_ptr_q <= ptr_inc(rd_ptr_q);
						end
						kind_q <= cleib_pkg::KIND_EOF;
						byte_q <= '0;
					end else begin
						rd_ptr_q   <= ptr_inc(rd_ptr_q);
						kind_q     <= cleib_pkg::KIND_READ;
						byte_q     <= ram_rdata;
						line_end_q <= (ram_rdata == cleib_pkg::KEY_LF);
					end
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (rsp.ready) begin
						if (bs_q && (beat_q != 2'd2)) begin
							beat_q <= beat_q + 2'd1;
							byte_q <= (beat_q == 2'd0) ? cleib_pkg::KEY_SP : cleib_pkg::KEY_BS;
							last_q <= (beat_q == 2'd1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = (state_q == ST_SEND);
	assign rsp.kind      = kind_q;
	assign rsp.byte_out  = byte_q;
	assign rsp.line_end  = line_end_q;
	assign rsp.committed = committed_q;
	assign rsp.last      = last_q;

endmodule

FILE: design/cleib_ram.sv
module cleib_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = cleib_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/cleib_chk.sv
module cleib_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input cleib_pkg::kind_t kind,
	input logic [7:0]       byte_out,
	input logic             line_end,
	input logic             committed,
	input logic             last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(byte_out)
			&& $stable(last))
		else $error("result beat changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("new item taken while a result is pending");

	a_commit_echo: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && committed |-> (kind == cleib_pkg::KIND_ECHO) && last)
		else $error("commit flag on a non-echo or non-final beat");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && line_end |-> (kind == cleib_pkg::KIND_READ)
			&& (byte_out == cleib_pkg::KEY_LF))
		else $error("line end without a popped line feed");

	a_single_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (kind != cleib_pkg::KIND_ECHO) |-> last)
		else $error("read result not marked last");

endmodule

bind console_line_edit_input_buffer cleib_chk u_cleib_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.kind      (rsp.kind),
	.byte_out  (rsp.byte_out),
	.line_end  (rsp.line_end),
	.committed (rsp.committed),
	.last      (rsp.last)
);

FILE: tb/tb.sv
module tb;
	import cleib_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int PW = $clog2(2 * DEPTH);
	localparam int TARGET_ITEMS = 480;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       line_end;
		logic       committed;
		logic       last;
	} con_out_t;

	typedef struct {
		action_t    act;
		logic [7:0] key;
		logic       cont;
		bit         typed;
		int         tn;
		con_out_t   res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	cleib_req_if req_ch();
	cleib_rsp_if rsp_ch();

	console_line_edit_input_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the line buffer
	logic [7:0]    ring_m [DEPTH];
	logic [PW-1:0] rd_p, cm_p, ed_p;
	con_out_t      pred_last;
	con_out_t      console_out_q [$];

	int  errors = 0;
	int  cycles = 0;
	int  items_sent = 0;
	int  productive = 0;
	int  beats_checked = 0;
	int  eof_seen = 0;
	int  full_drops = 0;
	int  erases = 0;
	bit  no_idle = 0;
	bit  hold_req = 0;
	int  hold_left = 0;

	dir_row_t dir_tab [24] = '{
		'{ACT_READ, KEY_NUL, 1'b0, 1'b1, 1, '{KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1}},
		'{ACT_KEY,  KEY_NUL, 1'b0, 1'b1, 0, '0},
		'{ACT_KEY,  KEY_DEL, 1'b0, 1'b1, 0, '0},
		'{ACT_KEY,  8'h61,   1'b0, 1'b1, 1, '{KIND_ECHO, 8'h61, 1'b0, 1'b0, 1'b1}},
		'{ACT_KEY,  8'hff,   1'b1, 1'b1, 1, '{KIND_ECHO, 8'hff, 1'b0, 1'b0, 1'b1}},
		'{ACT_KEY,  KEY_DEL, 1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  KEY_CR,  1'b0, 1'b1, 1, '{KIND_ECHO, KEY_LF, 1'b0, 1'b1, 1'b1}},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b1, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b1, 1, '{KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1}},
		'{ACT_KEY,  8'h01,   1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  KEY_EOT, 1'b0, 1'b1, 1, '{KIND_ECHO, KEY_EOT, 1'b0, 1'b1, 1'b1}},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b1, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b1, 1, '{KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1}},
		'{ACT_KEY,  KEY_LF,  1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  8'h80,   1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  8'h7e,   1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  KEY_DEL, 1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  KEY_DEL, 1'b0, 1'b0, 0, '0},
		'{ACT_KEY,  KEY_DEL, 1'b0, 1'b1, 0, '0},
		'{ACT_READ, 8'hff,   1'b1, 1'b0, 0, '0},
		'{ACT_READ, KEY_NUL, 1'b0, 1'b1, 1, '{KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1}}
	};

	function automatic con_out_t mk(kind_t kd, logic [7:0] d, logic le, logic cm, logic lst);
		mk = '{kind: kd, data: d, line_end: le, committed: cm, last: lst};
	endfunction

	// advances the shadow state; keep=0 when the row carries its own expectation
	task automatic line_disc_predict(input action_t act, input logic [7:0] k,
			input logic cont, input bit keep, output int n);
		con_out_t      r [3];
		logic [7:0]    c;
		logic [PW-1:0] held;
		logic          cm;
		n = 0;
		held = ed_p - rd_p;
		if (act == ACT_KEY) begin
			if (k == KEY_DEL) begin
				if (ed_p != cm_p) begin
					ed_p = ed_p - 1'b1;
					r[0] = mk(KIND_ECHO, KEY_BS, 1'b0, 1'b0, 1'b0);
					r[1] = mk(KIND_ECHO, KEY_SP, 1'b0, 1'b0, 1'b0);
					r[2] = mk(KIND_ECHO, KEY_BS, 1'b0, 1'b0, 1'b1);
					n = 3;
					erases++;
				end
			end else if (k == KEY_NUL) begin
				n = 0;
			end else if (held >= DEPTH) begin
				full_drops++;
			end else begin
				c = (k == KEY_CR) ? KEY_LF : k;
				ring_m[ed_p[PW-2:0]] = c;
				ed_p = ed_p + 1'b1;
				held = ed_p - rd_p;
				cm = (c == KEY_LF) || (c == KEY_EOT) || (held == DEPTH);
				if (cm)
					cm_p = ed_p;
				r[0] = mk(KIND_ECHO, c, 1'b0, cm, 1'b1);
				n = 1;
			end
		end else if (rd_p == cm_p) begin
			r[0] = mk(KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1);
			n = 1;
		end else begin
			c = ring_m[rd_p[PW-2:0]];
			if (c == KEY_EOT) begin
				if (!cont)
					rd_p = rd_p + 1'b1;
				r[0] = mk(KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b1);
				eof_seen++;
			end else begin
				rd_p = rd_p + 1'b1;
				r[0] = mk(KIND_READ, c, c == KEY_LF, 1'b0, 1'b1);
			end
			n = 1;
		end
		if (n > 0)
			pred_last = r[n-1];
		if (keep)
			for (int i = 0; i < n; i++)
				console_out_q.push_back(r[i]);
	endtask

	task automatic send_item(input action_t act, input logic [7:0] k, input logic cont,
			input bit typed, input int tn, input con_out_t tres);
		int n;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 35) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.key        <= k;
		req_ch.continuing <= cont;
		do @(posedge clk); while (!req_ch.ready);
		line_disc_predict(act, k, cont, !typed, n);
		if (typed && tn > 0)
			console_out_q.push_back(tres);
		items_sent++;
		if (n > 0)
			productive++;
	endtask

	// one read call: stops at line end, end of file, nothing committed or after 40 reads
	task automatic read_call();
		logic cont;
		cont = 1'b0;
		for (int i = 0; i < 40; i++) begin
			send_item(ACT_READ, 8'($urandom_range(255)), cont, 1'b0, 0, '0);
			if (pred_last.kind != KIND_READ || pred_last.line_end)
				break;
			cont = 1'b1;
		end
	endtask

	task automatic drain_ring();
		do send_item(ACT_READ, KEY_NUL, 1'b0, 1'b0, 0, '0);
		while (pred_last.kind != KIND_EMPTY);
	endtask

	function automatic void ck(string f, logic [7:0] e, logic [7:0] g);
		if (e !== g) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, f, e, g);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d beats pending", cycles,
				console_out_q.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		con_out_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (console_out_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat kind %0d byte %0h, expected none", $time,
					rsp_ch.kind, rsp_ch.byte_out);
			end else begin
				e = console_out_q.pop_front();
				ck("kind", 8'(e.kind), 8'(rsp_ch.kind));
				ck("byte_out", e.data, rsp_ch.byte_out);
				ck("line_end", 8'(e.line_end), 8'(rsp_ch.line_end));
				ck("committed", 8'(e.committed), 8'(rsp_ch.committed));
				ck("last", 8'(e.last), 8'(rsp_ch.last));
				beats_checked++;
			end
		end
	end

	initial begin
		int         r, len, p;
		logic [7:0] k;
		bit         press_done, fill_done;

		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_KEY;
		req_ch.key        = KEY_NUL;
		req_ch.continuing = 1'b0;
		rd_p = '0;
		cm_p = '0;
		ed_p = '0;
		pred_last = '0;
		press_done = 0;
		fill_done = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i])
			send_item(dir_tab[i].act, dir_tab[i].key, dir_tab[i].cont, dir_tab[i].typed,
				dir_tab[i].tn, dir_tab[i].res);

		while (items_sent < TARGET_ITEMS) begin
			no_idle = (items_sent >= 380 && items_sent < 450);
			if (!press_done && items_sent >= 60) begin
				press_done = 1;
				hold_req = 1'b1;
			end
			if (!fill_done && items_sent >= 100) begin
				// fill the ring to the brim, then push past it
				fill_done = 1;
				drain_ring();
				for (int i = 0; i < DEPTH + 3; i++)
					send_item(ACT_KEY, 8'($urandom_range(8'h21, 8'h7e)), 1'b0, 1'b0, 0, '0);
				send_item(ACT_KEY, KEY_DEL, 1'b0, 1'b0, 0, '0);
				drain_ring();
			end
			r = $urandom_range(99);
			if (r < 55) begin
				len = $urandom_range(0, 10);
				for (int i = 0; i < len; i++) begin
					p = $urandom_range(99);
					if (p < 12)
						k = KEY_DEL;
					else if (p < 14)
						k = KEY_NUL;
					else
						k = 8'($urandom_range(1, 255));
					send_item(ACT_KEY, k, 1'($urandom_range(1)), 1'b0, 0, '0);
				end
				case ($urandom_range(2))
					0: k = KEY_CR;
					1: k = KEY_LF;
					default: k = KEY_EOT;
				endcase
				send_item(ACT_KEY, k, 1'b0, 1'b0, 0, '0);
				if ($urandom_range(99) < 70)
					read_call();
			end else if (r < 85) begin
				read_call();
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(action_t'($urandom_range(1)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 1'b0, 0, '0);
			end
		end
		no_idle = 0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (console_out_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d items sent (%0d with results), %0d beats checked", items_sent,
			productive, beats_checked);
		$display("tb: %0d erases, %0d end-of-file reads, %0d keys dropped on full ring",
			erases, eof_seen, full_drops);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: console_line_edit_input_buffer.f
design/cleib_pkg.sv
design/cleib_req_if.sv
design/cleib_rsp_if.sv
design/cleib_ram.sv
design/console_line_edit_input_buffer.sv
design/cleib_chk.sv
tb/tb.sv
